>>> src/urh_pkg.sv
// ----------------------------------------------------------------------------
// urh_pkg
// Shared types and constants for the undo/redo history ring.
// ----------------------------------------------------------------------------
`default_nettype none

package urh_pkg;

    // Width of the step field and of the returned entry word
    localparam int STEP_W = 11;
    localparam int OUT_W  = 32;

    // Operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_UNDO   = 2'd1,
        KIND_REDO   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_urh_kind;

    // Store access request issued by the pointer control for one item
    typedef struct packed {
        logic wr;   // write the recorded entry
        logic rd;   // read an entry for undo or redo
        logic hit;  // the item returns an entry
    } t_urh_req;

endpackage

`default_nettype wire

>>> src/undo_redo_history_ring.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring
// Bounded edit history with record, multi-step undo/redo and clear.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result. An item is taken, the pointer
// and counts update and the store is written or read in the same cycle; the
// read word from the store is registered there and moves into the result
// register once that register is free or drains; the input takes no new
// item while one waits in this store read stage. While a result waits in
// the output register one further item can be taken and held until the
// register frees. Clear resets the pointer and counts only; store contents
// are not wiped, and no clearing pass is needed after reset. Entries keep
// the low DATA_W bits of the recorded word; the result shows the low 32
// bits of the entry and is zero when no entry is returned.
// ----------------------------------------------------------------------------
`default_nettype none

module undo_redo_history_ring #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // item input
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [31:0]                i_entry_data,
    input  wire logic [urh_pkg::STEP_W-1:0] i_step,
    // result output
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_has_entry,
    output logic [urh_pkg::OUT_W-1:0]       o_entry_out
);

    import urh_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic              accept;
    t_urh_req          req;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] rd_data;
    logic              s1_move;

    logic              r_s1_vld;
    logic              r_s1_hit;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [OUT_W-1:0]  r_out_data;

    // input transfer; one item in flight to the store at a time
    assign o_stall = r_s1_vld;
    assign accept  = i_valid && !r_s1_vld;

    urh_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (t_urh_kind'(i_kind)),
        .i_step   (i_step),
        .o_req    (req),
        .o_addr   (addr)
    );

    urh_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (req.wr),
        .i_rd_en   (req.rd),
        .i_addr    (addr),
        .i_wr_data (DATA_W'(i_entry_data)),
        .o_rd_data (rd_data)
    );

    // store read stage moves on when the result register is free or drains
    assign s1_move = r_s1_vld && (!r_out_vld || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload of the read stage and the result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hit <= req.hit;
        end
        if (s1_move) begin
            r_out_hit  <= r_s1_hit;
            r_out_data <= r_s1_hit ? OUT_W'(rd_data) : '0;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_has_entry = r_out_hit;
    assign o_entry_out = r_out_data;

endmodule

`default_nettype wire

>>> src/urh_store.sv
// ----------------------------------------------------------------------------
// urh_store
// History store: one write and one read per cycle at a shared address,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urh_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // read port, registered; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/urh_ctrl.sv
// ----------------------------------------------------------------------------
// urh_ctrl
// Write pointer and count bookkeeping; works out the store access for
// each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module urh_ctrl #(
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire urh_pkg::t_urh_kind         i_kind,
    input  wire logic [urh_pkg::STEP_W-1:0] i_step,
    output urh_pkg::t_urh_req               o_req,
    output logic      [$clog2(DEPTH)-1:0]   o_addr
);

    import urh_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;

    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_undone, n_undone;

    logic [CMP_W-1:0] step_x;
    logic [CMP_W-1:0] avail_x;
    logic [CMP_W-1:0] undone_x;
    logic [CNT_W-1:0] n_undo;
    logic [CNT_W-1:0] n_redo;
    logic [CNT_W-1:0] held_trim;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] ptr_undo;
    logic [PTR_W-1:0] ptr_redo;
    logic [PTR_W-1:0] addr_redo;
    logic             can_undo;
    logic             can_redo;

    // a + b modulo DEPTH, with b no larger than DEPTH
    function automatic logic [PTR_W-1:0] ring_fwd(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    // a - b modulo DEPTH, with b no larger than DEPTH
    function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] sum;
        if (SUM_W'(a) >= SUM_W'(b)) begin
            sum = SUM_W'(a) - SUM_W'(b);
        end else begin
            sum = SUM_W'(a) + SUM_W'(DEPTH) - SUM_W'(b);
        end
        return PTR_W'(sum);
    endfunction

    // step clamping and candidate pointers
    always_comb begin
        step_x    = (i_step == '0) ? CMP_W'(1) : CMP_W'(i_step);
        avail_x   = CMP_W'(r_held - r_undone);
        undone_x  = CMP_W'(r_undone);
        can_undo  = (r_undone < r_held);
        can_redo  = (r_undone != '0);
        n_undo    = (step_x < avail_x)  ? CNT_W'(step_x) : CNT_W'(avail_x);
        n_redo    = (step_x < undone_x) ? CNT_W'(step_x) : CNT_W'(undone_x);
        held_trim = r_held - r_undone;
        ptr_inc   = ring_fwd(r_ptr, CNT_W'(1));
        ptr_undo  = ring_back(r_ptr, n_undo);
        ptr_redo  = ring_fwd(r_ptr, n_redo);
        addr_redo = ring_fwd(r_ptr, n_redo - CNT_W'(1));
    end

    // next state and store request
    always_comb begin
        n_ptr    = r_ptr;
        n_held   = r_held;
        n_undone = r_undone;
        o_req    = '0;
        o_addr   = r_ptr;
        if (i_accept) begin
            case (i_kind)
                KIND_RECORD: begin
                    o_req.wr = 1'b1;
                    n_ptr    = ptr_inc;
                    n_undone = '0;
                    n_held   = (held_trim < CNT_W'(DEPTH)) ? held_trim + CNT_W'(1)
                                                           : held_trim;
                end
                KIND_UNDO: begin
                    if (can_undo) begin
                        o_req.rd  = 1'b1;
                        o_req.hit = 1'b1;
                        o_addr    = ptr_undo;
                        n_ptr     = ptr_undo;
                        n_undone  = r_undone + n_undo;
                    end
                end
                KIND_REDO: begin
                    if (can_redo) begin
                        o_req.rd  = 1'b1;
                        o_req.hit = 1'b1;
                        o_addr    = addr_redo;
                        n_ptr     = ptr_redo;
                        n_undone  = r_undone - n_redo;
                    end
                end
                KIND_CLEAR: begin
                    n_ptr    = '0;
                    n_held   = '0;
                    n_undone = '0;
                end
                default: begin
                    n_ptr = r_ptr;
                end
            endcase
        end
    end

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_held   <= '0;
            r_undone <= '0;
        end else begin
            r_ptr    <= n_ptr;
            r_held   <= n_held;
            r_undone <= n_undone;
        end
    end

endmodule

`default_nettype wire
